FILE: rtl/core/fqr_pkg.sv
// Shared codes, widths and controller/datapath interface types for the keyed run queue.
package fqr_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int OP_W  = 2;
   localparam int ID_W  = 16;
   localparam int ST_W  = 2;
   localparam int OCC_W = 5;

   localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
   localparam logic [OP_W-1:0] OP_POP    = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   localparam logic [ST_W-1:0] ST_DONE = 2'd0;
   localparam logic [ST_W-1:0] ST_MISS = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic            load;        // capture id, clear index and result id
      logic            set_status;
      logic [ST_W-1:0] status;
      logic            wr_push;     // write incoming id at the tail
      logic            inc_count;
      logic            dec_count;
      logic            inc_k;
      logic            rd_next;     // read entry k+1 instead of entry k
      logic            take_rid;
      logic            wr_shift;    // write read data back at entry k
      logic            out_load;
   } fqr_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic id_equal;
      logic at_last;
   } fqr_sts_type;

endpackage

FILE: rtl/core/fifo_queue_with_remove_by_id.sv
// Bounded run queue of process ids with push, pop and remove-by-id.
// Push goes straight to the result; pop and remove on a non-empty queue run a
// search walk over the queue memory and, on a hit, a shift walk that closes the gap.
// One item is in work at a time; a finished word waits in the output register
// while the next item is accepted.
// Reset clears the occupancy count and control state; queue entries are not cleared.
module fifo_queue_with_remove_by_id #(
   parameter int DEPTH = fqr_pkg::DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [fqr_pkg::OP_W-1:0]  req_operation,
   input  logic [fqr_pkg::ID_W-1:0]  req_process_id,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [fqr_pkg::ID_W-1:0]  rsp_result_id,
   output logic [fqr_pkg::ST_W-1:0]  rsp_status,
   output logic [fqr_pkg::OCC_W-1:0] rsp_occupancy
);

   fqr_pkg::fqr_cmd_type cmd;
   fqr_pkg::fqr_sts_type sts;

   fqr_controller u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .sts           (sts),
      .cmd           (cmd)
   );

   fqr_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_process_id (req_process_id),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_result_id  (rsp_result_id),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy)
   );

   // an accepted word keeps the input stalled while it is worked on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accept");

   a_id_only_when_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != fqr_pkg::ST_DONE) |-> (rsp_result_id == '0))
      else $error("result id set on a failed operation");

   a_push_never_over_full: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_push |-> !sts.full)
      else $error("push written into a full queue");

   a_shift_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_next || cmd.wr_shift) |-> !sts.empty)
      else $error("shift walk on an empty queue");

endmodule

FILE: rtl/core/fqr_datapath.sv
// Queue storage, occupancy count, walk index and result registers.
module fqr_datapath #(
   parameter int DEPTH = fqr_pkg::DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [fqr_pkg::ID_W-1:0]  req_process_id,
   input  fqr_pkg::fqr_cmd_type      cmd,
   output fqr_pkg::fqr_sts_type      sts,
   output logic [fqr_pkg::ID_W-1:0]  rsp_result_id,
   output logic [fqr_pkg::ST_W-1:0]  rsp_status,
   output logic [fqr_pkg::OCC_W-1:0] rsp_occupancy
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = CW + fqr_pkg::OCC_W;

   logic [fqr_pkg::ID_W-1:0]  mem [DEPTH];
   logic [fqr_pkg::ID_W-1:0]  rdata_ff;
   logic [fqr_pkg::ID_W-1:0]  id_ff;
   logic [fqr_pkg::ID_W-1:0]  rid_ff;
   logic [fqr_pkg::ST_W-1:0]  status_ff;
   logic [CW-1:0]             count_ff;
   logic [AW-1:0]             k_ff;
   logic [fqr_pkg::ID_W-1:0]  out_id_ff;
   logic [fqr_pkg::ST_W-1:0]  out_status_ff;
   logic [fqr_pkg::OCC_W-1:0] out_occ_ff;

   logic [AW-1:0]             raddr;
   logic [AW-1:0]             waddr;
   logic [fqr_pkg::ID_W-1:0]  wdata;
   logic                      wr_en;
   logic [CW-1:0]             k_plus_one;
   logic [XW-1:0]             count_wide;

   assign k_plus_one = CW'(k_ff) + CW'(1);
   assign raddr      = cmd.rd_next ? (k_ff + AW'(1)) : k_ff;
   assign wr_en      = cmd.wr_push | cmd.wr_shift;
   assign waddr      = cmd.wr_push ? count_ff[AW-1:0] : k_ff;
   assign wdata      = cmd.wr_push ? req_process_id : rdata_ff;
   assign count_wide = XW'(count_ff);

   assign sts.full     = (count_ff == CW'(DEPTH));
   assign sts.empty    = (count_ff == '0);
   assign sts.id_equal = (rdata_ff == id_ff);
   assign sts.at_last  = (k_plus_one >= count_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.inc_count) begin
         count_ff <= count_ff + CW'(1);
      end else if (cmd.dec_count) begin
         count_ff <= count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff     <= req_process_id;
         rid_ff    <= '0;
         k_ff      <= '0;
         status_ff <= cmd.status;
      end else begin
         if (cmd.inc_k) begin
            k_ff <= k_ff + AW'(1);
         end
         if (cmd.take_rid) begin
            rid_ff <= rdata_ff;
         end
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
      end
   end

   // hold the finished word until the controller loads the next one
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_id_ff     <= rid_ff;
         out_status_ff <= status_ff;
         out_occ_ff    <= count_wide[fqr_pkg::OCC_W-1:0];
      end
   end

   assign rsp_result_id = out_id_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_occupancy = out_occ_ff;

endmodule

FILE: rtl/core/fqr_controller.sv
// Sequencer for push, pop and remove: search walk, gap-closing shift and result hand-off.
module fqr_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [fqr_pkg::OP_W-1:0] req_operation,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  fqr_pkg::fqr_sts_type     sts,
   output fqr_pkg::fqr_cmd_type     cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SRCH = 3'd1;
   localparam logic [2:0] S_CMP  = 3'd2;
   localparam logic [2:0] S_SHRD = 3'd3;
   localparam logic [2:0] S_SHWR = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       pop_ff, pop_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;
   logic       match;

   assign accept   = req_valid & ~req_stall;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign match    = pop_ff | sts.id_equal;

   always_comb begin
      state_in = state_ff;
      pop_in   = pop_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load   = 1'b1;
               cmd.status = fqr_pkg::ST_MISS;
               pop_in     = (req_operation == fqr_pkg::OP_POP);
               state_in   = S_FIN;
               case (req_operation)
                  fqr_pkg::OP_PUSH: begin
                     if (sts.full) begin
                        cmd.status = fqr_pkg::ST_FULL;
                     end else begin
                        cmd.status    = fqr_pkg::ST_DONE;
                        cmd.wr_push   = 1'b1;
                        cmd.inc_count = 1'b1;
                     end
                  end
                  fqr_pkg::OP_POP, fqr_pkg::OP_REMOVE: begin
                     if (!sts.empty) begin
                        state_in = S_SRCH;
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_SRCH: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.set_status = 1'b1;
            if (match) begin
               cmd.status   = fqr_pkg::ST_DONE;
               cmd.take_rid = 1'b1;
               state_in     = S_SHRD;
            end else if (sts.at_last) begin
               cmd.status = fqr_pkg::ST_MISS;
               state_in   = S_FIN;
            end else begin
               cmd.set_status = 1'b0;
               cmd.inc_k      = 1'b1;
               state_in       = S_SRCH;
            end
         end
         S_SHRD: begin
            if (sts.at_last) begin
               cmd.dec_count = 1'b1;
               state_in      = S_FIN;
            end else begin
               cmd.rd_next = 1'b1;
               state_in    = S_SHWR;
            end
         end
         S_SHWR: begin
            // move entry k+1 down into the gap and advance
            cmd.wr_shift = 1'b1;
            cmd.inc_k    = 1'b1;
            state_in     = S_SHRD;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pop_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pop_ff       <= pop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
